FILE: hdl/one_wire_bus_master_defines.svh
// Assertion macros used by the top RTL file of the one-wire bus master.
// Every check is clocked on clk and is off while rst_n is low.
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OWM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/owm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package owm_pkg;

  localparam int TIMER_BITS_DEF = 10;
  localparam int CFG_WIDTH      = 10;
  localparam int CFG_COUNT      = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int BYTE_W         = 8;
  localparam int BIT_CNT_W      = 4;

  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_RESET_LOW     = 3'd0;
  localparam cfg_idx_t CFG_RESET_RELEASE = 3'd1;
  localparam cfg_idx_t CFG_SHORT_LOW     = 3'd2;
  localparam cfg_idx_t CFG_LONG_SLOT     = 3'd3;
  localparam cfg_idx_t CFG_READ_SAMPLE   = 3'd4;
  localparam cfg_idx_t CFG_READ_TAIL     = 3'd5;
  localparam cfg_idx_t CFG_PRES_WAIT     = 3'd6;
  localparam cfg_idx_t CFG_PRES_LOW      = 3'd7;

  typedef logic [CFG_WIDTH-1:0] cfg_word_t;

  localparam cfg_word_t CFG_DEFAULTS [CFG_COUNT] = '{
    10'd750, 10'd15, 10'd2, 10'd60, 10'd12, 10'd50, 10'd200, 10'd240
  };

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_REL   = 4'd2,
    PH_PRES_LOW  = 4'd3,
    PH_PRES_HIGH = 4'd4,
    PH_W_LOW     = 4'd5,
    PH_W_REL     = 4'd6,
    PH_R_LOW     = 4'd7,
    PH_R_WAIT    = 4'd8,
    PH_R_TAIL    = 4'd9
  } phase_t;

  typedef struct packed {
    op_t              operation;
    logic [BYTE_W-1:0] write_data;
    logic             line_level;
  } in_item_t;

  typedef struct packed {
    logic             drive_low;
    logic             busy_res;
    logic             done_res;
    logic [BYTE_W-1:0] read_data;
    logic             presence_fail;
  } out_item_t;

  typedef struct packed {
    logic                 idle;
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/owm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module owm_cfg #(
  parameter int TIMER_BITS = owm_pkg::TIMER_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire owm_pkg::cfg_idx_t        cfg_index,
  input  wire owm_pkg::cfg_word_t       cfg_wdata,
  output logic      [TIMER_BITS-1:0]    lim [owm_pkg::CFG_COUNT]
);

  localparam int CW = (TIMER_BITS > owm_pkg::CFG_WIDTH) ? TIMER_BITS : owm_pkg::CFG_WIDTH;
  localparam logic [CW-1:0] CMAX = CW'((64'd1 << TIMER_BITS) - 64'd1);
  localparam logic [CW-1:0] ONE  = CW'(1);

  owm_pkg::cfg_word_t regs_r [owm_pkg::CFG_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < owm_pkg::CFG_COUNT; i++) begin
        regs_r[i] <= owm_pkg::CFG_DEFAULTS[i];
      end
    end else if (cfg_we) begin
      regs_r[cfg_index] <= cfg_wdata;
    end
  end

  // A zero limit behaves as one, and a limit beyond the counter range is clamped.
  always_comb begin
    logic [CW-1:0] v;
    for (int i = 0; i < owm_pkg::CFG_COUNT; i++) begin
      v = CW'(regs_r[i]);
      if (v == '0) begin
        v = ONE;
      end else if (v > CMAX) begin
        v = CMAX;
      end
      lim[i] = v[TIMER_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/owm_fsm.sv
`timescale 1ns / 1ps
`default_nettype none

module owm_fsm #(
  parameter int TIMER_BITS = owm_pkg::TIMER_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step_en,
  input  wire owm_pkg::in_item_t     item,
  input  wire logic [TIMER_BITS-1:0] lim [owm_pkg::CFG_COUNT],
  output owm_pkg::out_item_t         res,
  output owm_pkg::status_t           status
);

  localparam logic [TIMER_BITS-1:0] TICK_MAX = '1;

  owm_pkg::phase_t                      phase_r, phase_nxt;
  logic [TIMER_BITS-1:0]                tick_r, tick_nxt;
  logic [owm_pkg::BIT_CNT_W-1:0]        bit_r, bit_nxt;
  logic [owm_pkg::BYTE_W-1:0]           shift_r, shift_nxt;
  logic [owm_pkg::BYTE_W-1:0]           recv_r, recv_nxt;
  logic                                 fail_r, fail_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= owm_pkg::PH_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      recv_r  <= '0;
      fail_r  <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      recv_r  <= recv_nxt;
      fail_r  <= fail_nxt;
    end
  end

  always_comb begin
    owm_pkg::phase_t               ph_e;
    logic [TIMER_BITS-1:0]         tick_e;
    logic [TIMER_BITS-1:0]         tick_inc;
    logic [owm_pkg::BIT_CNT_W-1:0] bit_e;
    logic [owm_pkg::BIT_CNT_W-1:0] bit_inc;
    logic [owm_pkg::BYTE_W-1:0]    shift_e;
    logic [owm_pkg::BYTE_W-1:0]    shift_smp;
    owm_pkg::cfg_idx_t             lim_idx;
    logic                          bitv;
    logic                          reached;
    logic                          drive;
    logic                          done;

    ph_e    = phase_r;
    tick_e  = tick_r;
    bit_e   = bit_r;
    shift_e = shift_r;

    // A request is taken only while idle, and this beat is its first tick.
    if (phase_r == owm_pkg::PH_IDLE && item.operation != owm_pkg::OP_NONE) begin
      bit_e  = '0;
      tick_e = '0;
      case (item.operation)
        owm_pkg::OP_RESET: begin
          ph_e = owm_pkg::PH_RST_LOW;
        end
        owm_pkg::OP_WRITE: begin
          ph_e    = owm_pkg::PH_W_LOW;
          shift_e = item.write_data;
        end
        default: begin
          ph_e    = owm_pkg::PH_R_LOW;
          shift_e = '0;
        end
      endcase
    end

    bitv      = shift_e[0];
    tick_inc  = (tick_e == TICK_MAX) ? tick_e : tick_e + 1'b1;
    bit_inc   = bit_e + 1'b1;
    shift_smp = (tick_e == '0) ? {item.line_level, shift_e[owm_pkg::BYTE_W-1:1]} : shift_e;

    case (ph_e)
      owm_pkg::PH_RST_LOW:   lim_idx = owm_pkg::CFG_RESET_LOW;
      owm_pkg::PH_RST_REL:   lim_idx = owm_pkg::CFG_RESET_RELEASE;
      owm_pkg::PH_PRES_LOW:  lim_idx = owm_pkg::CFG_PRES_WAIT;
      owm_pkg::PH_PRES_HIGH: lim_idx = owm_pkg::CFG_PRES_LOW;
      owm_pkg::PH_W_LOW:     lim_idx = bitv ? owm_pkg::CFG_SHORT_LOW : owm_pkg::CFG_LONG_SLOT;
      owm_pkg::PH_W_REL:     lim_idx = bitv ? owm_pkg::CFG_LONG_SLOT : owm_pkg::CFG_SHORT_LOW;
      owm_pkg::PH_R_WAIT:    lim_idx = owm_pkg::CFG_READ_SAMPLE;
      owm_pkg::PH_R_TAIL:    lim_idx = owm_pkg::CFG_READ_TAIL;
      default:               lim_idx = owm_pkg::CFG_SHORT_LOW;
    endcase
    reached = (tick_inc >= lim[lim_idx]);

    phase_nxt = ph_e;
    tick_nxt  = tick_inc;
    bit_nxt   = bit_e;
    shift_nxt = shift_e;
    recv_nxt  = recv_r;
    fail_nxt  = fail_r;
    drive     = 1'b0;
    done      = 1'b0;

    case (ph_e)
      owm_pkg::PH_RST_LOW: begin
        drive = 1'b1;
        if (reached) begin
          phase_nxt = owm_pkg::PH_RST_REL;
          tick_nxt  = '0;
        end
      end
      owm_pkg::PH_RST_REL: begin
        if (reached) begin
          phase_nxt = owm_pkg::PH_PRES_LOW;
          tick_nxt  = '0;
        end
      end
      owm_pkg::PH_PRES_LOW: begin
        if (!item.line_level) begin
          phase_nxt = owm_pkg::PH_PRES_HIGH;
          tick_nxt  = '0;
        end else if (reached) begin
          fail_nxt  = 1'b1;
          done      = 1'b1;
          phase_nxt = owm_pkg::PH_IDLE;
          tick_nxt  = '0;
        end
      end
      owm_pkg::PH_PRES_HIGH: begin
        if (item.line_level) begin
          fail_nxt  = 1'b0;
          done      = 1'b1;
          phase_nxt = owm_pkg::PH_IDLE;
          tick_nxt  = '0;
        end else if (reached) begin
          fail_nxt  = 1'b1;
          done      = 1'b1;
          phase_nxt = owm_pkg::PH_IDLE;
          tick_nxt  = '0;
        end
      end
      owm_pkg::PH_W_LOW: begin
        drive = 1'b1;
        if (reached) begin
          phase_nxt = owm_pkg::PH_W_REL;
          tick_nxt  = '0;
        end
      end
      owm_pkg::PH_W_REL: begin
        if (reached) begin
          shift_nxt = shift_e >> 1;
          bit_nxt   = bit_inc;
          tick_nxt  = '0;
          if (bit_inc >= owm_pkg::BITS_PER_BYTE) begin
            done      = 1'b1;
            phase_nxt = owm_pkg::PH_IDLE;
          end else begin
            phase_nxt = owm_pkg::PH_W_LOW;
          end
        end
      end
      owm_pkg::PH_R_LOW: begin
        drive = 1'b1;
        if (reached) begin
          phase_nxt = owm_pkg::PH_R_WAIT;
          tick_nxt  = '0;
        end
      end
      owm_pkg::PH_R_WAIT: begin
        if (reached) begin
          phase_nxt = owm_pkg::PH_R_TAIL;
          tick_nxt  = '0;
        end
      end
      owm_pkg::PH_R_TAIL: begin
        shift_nxt = shift_smp;
        if (reached) begin
          bit_nxt  = bit_inc;
          tick_nxt = '0;
          if (bit_inc >= owm_pkg::BITS_PER_BYTE) begin
            recv_nxt  = shift_smp;
            done      = 1'b1;
            phase_nxt = owm_pkg::PH_IDLE;
          end else begin
            phase_nxt = owm_pkg::PH_R_LOW;
          end
        end
      end
      default: begin
        phase_nxt = owm_pkg::PH_IDLE;
        tick_nxt  = '0;
      end
    endcase

    res.drive_low     = drive;
    res.busy_res      = (ph_e != owm_pkg::PH_IDLE);
    res.done_res      = done;
    res.read_data     = recv_nxt;
    res.presence_fail = fail_nxt;
  end

  assign status.idle      = (phase_r == owm_pkg::PH_IDLE);

endmodule

`default_nettype wire

FILE: hdl/one_wire_bus_master.sv
// One-wire bus master stepped once per microsecond tick. Each input beat is one tick
// carrying an operation request (none, reset with presence detect, write byte, read
// byte, LSB first) and the sampled line level; each beat yields exactly one result
// beat with the line drive, busy and done flags, the last read byte and the presence
// fail flag. A request is taken only while the master is idle and is ignored while
// busy. The block takes one beat every clock cycle unless the result register is full
// and not read: a beat is captured in an input register, then the phase sequencer
// advances its state and fills the result register, so the rate is limited only by
// the result consumer. The user must write timing registers through the cfg_ port only
// while no beat is held inside and no result is waiting; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

`include "one_wire_bus_master_defines.svh"

module one_wire_bus_master #(
  parameter int TIMER_BITS = owm_pkg::TIMER_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire owm_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output owm_pkg::out_item_t       out_data,
  input  wire logic                cfg_we,
  input  wire owm_pkg::cfg_idx_t   cfg_index,
  input  wire owm_pkg::cfg_word_t  cfg_wdata
);

  logic                  inq_valid_r;
  owm_pkg::in_item_t     inq_r;
  logic                  out_valid_r;
  owm_pkg::out_item_t    out_data_r;
  logic                  step_en;
  owm_pkg::out_item_t    res;
  owm_pkg::status_t      status;
  logic [TIMER_BITS-1:0] lim [owm_pkg::CFG_COUNT];

  assign step_en  = inq_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !inq_valid_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_ready) begin
      inq_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      inq_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  owm_cfg #(
    .TIMER_BITS(TIMER_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .lim       (lim)
  );

  owm_fsm #(
    .TIMER_BITS(TIMER_BITS)
  ) u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (inq_r),
    .lim     (lim),
    .res     (res),
    .status  (status)
  );

  `OWM_ASSERT_NEXT(a_done_goes_idle, step_en && res.done_res, status.idle, "done but not idle")
  `OWM_ASSERT_SAME(a_no_overrun, inq_valid_r && out_valid_r && !out_ready, !in_ready, "overrun")
  `OWM_ASSERT_NEXT(a_idle_holds, status.idle && !step_en, status.idle, "left idle without a beat")

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps

import owm_pkg::*;

class tick_scoreboard;
  localparam int unsigned TICK_MAX = (1 << TIMER_BITS_DEF) - 1;

  cfg_word_t timing [CFG_COUNT];
  phase_t phase;
  logic [TIMER_BITS_DEF-1:0] tick_count;
  logic [BIT_CNT_W-1:0] bit_count;
  logic [BYTE_W-1:0] shift_byte;
  logic [BYTE_W-1:0] received_byte;
  logic fail_flag;
  out_item_t line_results [$];
  int mismatches;
  int beats_seen;

  function new();
    foreach (timing[i]) timing[i] = CFG_DEFAULTS[i];
    phase = PH_IDLE;
    tick_count = '0;
    bit_count = '0;
    shift_byte = '0;
    received_byte = '0;
    fail_flag = 1'b0;
    mismatches = 0;
    beats_seen = 0;
  endfunction

  function void write_timing(cfg_idx_t idx, cfg_word_t val);
    timing[idx] = val;
  endfunction

  // A zero register behaves as one, and nothing can exceed the counter range.
  function int unsigned limit(cfg_idx_t idx);
    int unsigned v;
    v = timing[idx];
    if (v == 0) v = 1;
    if (v > TICK_MAX) v = TICK_MAX;
    return v;
  endfunction

  function bit count_tick(cfg_idx_t idx);
    if (tick_count < TICK_MAX) tick_count = tick_count + 1'b1;
    return tick_count >= limit(idx);
  endfunction

  function void enter(phase_t p);
    phase = p;
    tick_count = '0;
  endfunction

  function void log_tick(in_item_t b);
    out_item_t r;
    logic bitv;
    r = '0;
    if (phase == PH_IDLE && b.operation != OP_NONE) begin
      bit_count = '0;
      case (b.operation)
        OP_RESET: enter(PH_RST_LOW);
        OP_WRITE: begin
          shift_byte = b.write_data;
          enter(PH_W_LOW);
        end
        default: begin
          shift_byte = '0;
          enter(PH_R_LOW);
        end
      endcase
    end
    r.busy_res = (phase != PH_IDLE);
    bitv = shift_byte[0];
    case (phase)
      PH_RST_LOW: begin
        r.drive_low = 1'b1;
        if (count_tick(CFG_RESET_LOW)) enter(PH_RST_REL);
      end
      PH_RST_REL: begin
        if (count_tick(CFG_RESET_RELEASE)) enter(PH_PRES_LOW);
      end
      PH_PRES_LOW: begin
        if (!b.line_level) begin
          enter(PH_PRES_HIGH);
        end else if (count_tick(CFG_PRES_WAIT)) begin
          fail_flag = 1'b1;
          r.done_res = 1'b1;
          enter(PH_IDLE);
        end
      end
      PH_PRES_HIGH: begin
        if (b.line_level) begin
          fail_flag = 1'b0;
          r.done_res = 1'b1;
          enter(PH_IDLE);
        end else if (count_tick(CFG_PRES_LOW)) begin
          fail_flag = 1'b1;
          r.done_res = 1'b1;
          enter(PH_IDLE);
        end
      end
      PH_W_LOW: begin
        r.drive_low = 1'b1;
        if (count_tick(bitv ? CFG_SHORT_LOW : CFG_LONG_SLOT)) enter(PH_W_REL);
      end
      PH_W_REL: begin
        if (count_tick(bitv ? CFG_LONG_SLOT : CFG_SHORT_LOW)) begin
          shift_byte = shift_byte >> 1;
          bit_count = bit_count + 1'b1;
          if (bit_count >= BITS_PER_BYTE) begin
            r.done_res = 1'b1;
            enter(PH_IDLE);
          end else begin
            enter(PH_W_LOW);
          end
        end
      end
      PH_R_LOW: begin
        r.drive_low = 1'b1;
        if (count_tick(CFG_SHORT_LOW)) enter(PH_R_WAIT);
      end
      PH_R_WAIT: begin
        if (count_tick(CFG_READ_SAMPLE)) enter(PH_R_TAIL);
      end
      PH_R_TAIL: begin
        if (tick_count == 0) shift_byte = {b.line_level, shift_byte[BYTE_W-1:1]};
        if (count_tick(CFG_READ_TAIL)) begin
          bit_count = bit_count + 1'b1;
          if (bit_count >= BITS_PER_BYTE) begin
            received_byte = shift_byte;
            r.done_res = 1'b1;
            enter(PH_IDLE);
          end else begin
            enter(PH_R_LOW);
          end
        end
      end
      default: enter(PH_IDLE);
    endcase
    r.read_data = received_byte;
    r.presence_fail = fail_flag;
    line_results.push_back(r);
  endfunction

  function void check_tick(out_item_t got);
    out_item_t want;
    beats_seen++;
    if (line_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result beat %0d arrived with nothing outstanding", beats_seen);
      return;
    end
    want = line_results.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"beat %0d: expected drive=%b busy=%b done=%b data=%h fail=%b,",
                  " got drive=%b busy=%b done=%b data=%h fail=%b"}, beats_seen,
                 want.drive_low, want.busy_res, want.done_res, want.read_data,
                 want.presence_fail, got.drive_low, got.busy_res, got.done_res,
                 got.read_data, got.presence_fail);
    end
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = '0;
  cfg_word_t cfg_wdata = '0;

  tick_scoreboard sb = new();
  int cycle_count = 0;
  int burst_left = 0;
  int resp_wait = 0;
  int resp_low = 0;
  bit hold_req = 1'b0;

  one_wire_bus_master u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_tick(out_data);
  end

  // The device answers a reset by pulling the line low after resp_wait high
  // ticks and releasing it after resp_low low ticks; a negative resp_wait
  // leaves the line random.
  task automatic make_beat(input bit forced, input op_t fop, output in_item_t b);
    int lw, ll, pick;
    b.write_data = 8'($urandom);
    b.line_level = 1'($urandom);
    if (forced) b.operation = fop;
    else if (sb.phase == PH_IDLE && $urandom_range(0, 7) != 0)
      b.operation = op_t'($urandom_range(1, 3));
    else b.operation = op_t'($urandom_range(0, 3));
    if (sb.phase == PH_IDLE && b.operation == OP_RESET) begin
      lw = sb.limit(CFG_PRES_WAIT);
      ll = sb.limit(CFG_PRES_LOW);
      pick = $urandom_range(0, 9);
      resp_wait = $urandom_range(0, lw - 1);
      resp_low = $urandom_range(0, ll - 1);
      if (pick == 6) resp_wait = lw + $urandom_range(0, 3);
      else if (pick == 7) resp_low = ll + $urandom_range(0, 3);
      else if (pick == 8) begin
        resp_wait = lw - 1;
        resp_low = ll - 1;
      end else if (pick == 9) resp_wait = -1;
    end else if (resp_wait >= 0 && sb.phase == PH_PRES_LOW) begin
      b.line_level = (int'(sb.tick_count) < resp_wait);
    end else if (resp_wait >= 0 && sb.phase == PH_PRES_HIGH) begin
      b.line_level = (int'(sb.tick_count) >= resp_low);
    end
  endtask

  // Entered and left just after a falling edge.
  task automatic push_beat(input in_item_t b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    sb.log_tick(b);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic run_op(input op_t op, input logic [BYTE_W-1:0] data, input int w,
                        input int l);
    in_item_t b;
    make_beat(1'b1, op, b);
    b.write_data = data;
    if (op == OP_RESET) begin
      resp_wait = w;
      resp_low = l;
    end
    push_beat(b);
    while (sb.phase != PH_IDLE) begin
      make_beat(1'b0, OP_NONE, b);
      push_beat(b);
    end
  endtask

  task automatic random_ops(input int n);
    int acted;
    bit was_idle;
    in_item_t b;
    acted = 0;
    while (acted < n) begin
      was_idle = (sb.phase == PH_IDLE);
      make_beat(1'b0, OP_NONE, b);
      push_beat(b);
      if (was_idle) acted++;
    end
  endtask

  task automatic apply_timing(input cfg_word_t vals [CFG_COUNT]);
    in_item_t b;
    while (sb.phase != PH_IDLE) begin
      make_beat(1'b0, OP_NONE, b);
      push_beat(b);
    end
    in_valid <= 1'b0;
    while (sb.line_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    for (int i = 0; i < CFG_COUNT; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= vals[i];
      sb.write_timing(cfg_idx_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int mode, len;
    bit hold_served;
    hold_served = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(8, 64);
      repeat (len) begin
        @(negedge clk);
        if (hold_req && !hold_served) begin
          hold_served = 1'b1;
          out_ready <= 1'b0;
          repeat (400) @(negedge clk);
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom);
            2: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ~out_ready;
          endcase
        end
      end
    end
  end

  initial begin
    cfg_word_t vals [CFG_COUNT];
    in_item_t b;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Idle beats with no request, then each operation at a short timing.
    repeat (2) begin
      make_beat(1'b1, OP_NONE, b);
      push_beat(b);
    end
    vals = '{10'd4, 10'd2, 10'd1, 10'd3, 10'd2, 10'd3, 10'd6, 10'd6};
    apply_timing(vals);
    run_op(OP_RESET, 8'h00, 2, 3);
    run_op(OP_RESET, 8'h00, 20, 0);
    run_op(OP_RESET, 8'h00, 0, 20);
    run_op(OP_RESET, 8'h00, 5, 5);
    run_op(OP_WRITE, 8'hA5, 0, 0);
    run_op(OP_READ, 8'h00, 0, 0);

    foreach (vals[i]) vals[i] = 10'd1;
    apply_timing(vals);
    random_ops(8);

    foreach (vals[i]) vals[i] = 10'd0;
    apply_timing(vals);
    random_ops(6);

    foreach (vals[i]) vals[i] = cfg_word_t'($urandom_range(1, 3));
    apply_timing(vals);
    hold_req = 1'b1;
    random_ops(5);

    foreach (vals[i]) vals[i] = cfg_word_t'($urandom_range(0, 4));
    apply_timing(vals);
    random_ops(4);

    in_valid <= 1'b0;
    while (sb.line_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.mismatches == 0 && sb.line_results.size() == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule
